@@ sv/gvt_token_ring_engine_defines.svh @@
// Assertion macros for the global virtual time engine
`ifndef GVT_TOKEN_RING_ENGINE_DEFINES_SVH
`define GVT_TOKEN_RING_ENGINE_DEFINES_SVH
`define GVT_ASSERT_IMPL(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("gvt check failed");
`define GVT_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("gvt check failed");
`endif

@@ sv/gvt_pkg.sv @@
// Types and constants shared by the global virtual time engine
package gvt_pkg;
  localparam int MAX_THREADS = 16;
  localparam logic [31:0] INF_TIME = 32'hFFFF_FFFF;
  localparam logic [2:0] K_TICK = 3'd0;
  localparam logic [2:0] K_START = 3'd1;
  localparam logic [2:0] K_SENT = 3'd2;
  localparam logic [2:0] K_RECV = 3'd3;
  localparam logic [2:0] K_TOKEN = 3'd4;
  localparam logic [2:0] K_TIME = 3'd5;
  localparam logic [2:0] K_TMIN = 3'd6;
  localparam logic [2:0] K_SMIN = 3'd7;
  localparam logic [1:0] R_STATUS = 2'd0;
  localparam logic [1:0] R_TOKEN = 2'd1;
  localparam logic [1:0] R_UPDATE = 2'd2;
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LOCAL = 2'd1;
  localparam logic [1:0] PH_GLOBAL = 2'd2;
  localparam logic [1:0] CFG_NODE = 2'd0;
  localparam logic [1:0] CFG_PROC = 2'd1;
  localparam logic [1:0] CFG_THREAD = 2'd2;

  typedef struct packed {
    logic load;       // capture input item
    logic exec;       // apply item to state (single cycle updates)
    logic clr_step;   // clear one thread slot
    logic red_step;   // fold one thread minimum
    logic red_init;
    logic mod_step;   // one step of the next node remainder
    logic bc_init;
    logic emit_status;
    logic emit_bcast;
    logic fin_tick;   // finish local round reduction
  } gvt_cmd_t;

  typedef struct packed {
    logic       tick_start;  // tick starts a round
    logic       tick_reduce; // tick reduces
    logic       bcast;       // token arrival at initiator broadcasts
    logic       idx_last;    // walk index at end
    logic       mod_last;
    logic       bc_last;
  } gvt_stat_t;
endpackage

@@ sv/gvt_ctrl.sv @@
// Controller sequencing one item through the engine datapath
module gvt_ctrl import gvt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  gvt_stat_t stat,
  output gvt_cmd_t  cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC = 3'd1;
  localparam logic [2:0] S_CLR = 3'd2;
  localparam logic [2:0] S_RED = 3'd3;
  localparam logic [2:0] S_BC = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;
  localparam logic [2:0] S_MOD = 3'd6;
  localparam logic [2:0] S_FIN = 3'd7;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (stat.tick_start) begin
          state_next = S_CLR;
        end else if (stat.tick_reduce) begin
          cmd.red_init = 1'b1;
          state_next = S_RED;
        end else if (stat.bcast) begin
          cmd.exec = 1'b1;
          cmd.bc_init = 1'b1;
          state_next = S_BC;
        end else begin
          cmd.exec = 1'b1;
          state_next = S_OUT;
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (stat.idx_last) begin
          cmd.exec = 1'b1;
          state_next = S_OUT;
        end
      end
      S_RED: begin
        cmd.red_step = 1'b1;
        if (stat.idx_last) state_next = S_MOD;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.fin_tick = 1'b1;
        state_next = S_IDLE;
      end
      S_BC: begin
        cmd.emit_bcast = 1'b1;
        if (stat.bc_last) state_next = S_IDLE;
      end
      S_OUT: begin
        cmd.emit_status = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

@@ sv/gvt_dp.sv @@
// Datapath: engine state, thread tables and result formation
module gvt_dp import gvt_pkg::*; #(
  parameter int MAX_NODES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  gvt_cmd_t    cmd,
  output gvt_stat_t   stat,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [2:0]  kind,
  input  logic [31:0] timestamp,
  input  logic        msg_color,
  input  logic [4:0]  thread_index,
  input  logic        round_seen,
  input  logic [31:0] token_clock,
  input  logic [31:0] token_send,
  input  logic signed [31:0] token_count,
  input  logic [31:0] new_time,
  output logic        result_valid,
  output logic [1:0]  result_kind,
  output logic [5:0]  dest_node,
  output logic        send_color,
  output logic [31:0] out_clock,
  output logic [31:0] out_send,
  output logic signed [31:0] out_count,
  output logic [31:0] current_time,
  output logic        time_fresh,
  output logic [4:0]  pending_threads,
  output logic        last
);
  localparam int SLOTS = MAX_THREADS + 1;
  localparam int IW = $clog2(SLOTS + 1);

  logic [5:0] node_id;
  logic [6:0] process_count;
  logic [4:0] thread_count;
  logic [2:0] r_kind;
  logic [31:0] r_ts, r_tclk, r_tsnd, r_tcnt, r_new;
  logic r_mcol, r_seen;
  logic [4:0] r_ti;

  logic [1:0] phase;
  logic cur_color, base_color, time_updated, local_started, global_started;
  logic [31:0] white_count, red_count, held_count, red_min, ring_min_clock, time_value;
  logic [4:0] waiting_threads;
  logic [31:0] thread_min [SLOTS];
  logic [31:0] thread_send_min [SLOTS];
  logic [SLOTS-1:0] thread_done;
  logic [IW-1:0] idx;
  logic [31:0] acc;
  logic [6:0] bc;
  logic [31:0] bc_time;
  logic [6:0] rem;
  logic [2:0] mod_k;

  logic [6:0] pc;
  logic [4:0] tc;
  logic [IW-1:0] tc_i;
  logic [31:0] base_val;
  logic [12:0] mod_sub;
  logic slot_ok;
  logic [IW-1:0] ti_i;

  always_comb begin
    if (process_count == 7'd0) pc = 7'd1;
    else if (process_count > 7'(MAX_NODES)) pc = 7'(MAX_NODES);
    else pc = process_count;
    tc = (thread_count > 5'(MAX_THREADS)) ? 5'(MAX_THREADS) : thread_count;
    tc_i = IW'(tc);
    ti_i = IW'(r_ti);
    slot_ok = ({1'b0, r_ti} <= 6'(tc));
    base_val = base_color ? red_count : white_count;
    mod_sub = 13'(pc) << mod_k;
  end

  assign stat.tick_start = (r_kind == K_TICK) && (phase == PH_LOCAL) &&
                           (waiting_threads == 5'd0) && !local_started;
  assign stat.tick_reduce = (r_kind == K_TICK) && (phase == PH_LOCAL) &&
                            (waiting_threads == 5'd0) && local_started;
  assign stat.bcast = (r_kind == K_TOKEN) && (node_id == 6'd0) &&
                      (r_tcnt[31] || r_tcnt == 32'd0);
  assign stat.idx_last = (idx == tc_i);
  assign stat.mod_last = (mod_k == 3'd0);
  assign stat.bc_last = (bc == pc - 7'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      node_id <= '0; process_count <= 7'd1; thread_count <= 5'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_NODE: node_id <= cfg_data[5:0];
        CFG_PROC: process_count <= cfg_data[6:0];
        CFG_THREAD: thread_count <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_kind <= kind; r_ts <= timestamp; r_mcol <= msg_color; r_ti <= thread_index;
      r_seen <= round_seen; r_tclk <= token_clock; r_tsnd <= token_send;
      r_tcnt <= token_count; r_new <= new_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE; cur_color <= 1'b0; base_color <= 1'b0;
      white_count <= '0; red_count <= '0; held_count <= '0;
      red_min <= INF_TIME; ring_min_clock <= INF_TIME; time_value <= '0;
      time_updated <= 1'b0; local_started <= 1'b0; global_started <= 1'b0;
      waiting_threads <= '0; thread_done <= '0; idx <= '0;
      result_valid <= 1'b0; last <= 1'b0; bc <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        thread_min[i] <= INF_TIME; thread_send_min[i] <= INF_TIME;
      end
    end else begin
      result_valid <= cmd.emit_status | cmd.emit_bcast | cmd.fin_tick;
      last <= cmd.emit_status | cmd.fin_tick | (cmd.emit_bcast & stat.bc_last);
      if (cmd.load) idx <= '0;
      if (cmd.clr_step) begin
        thread_min[idx] <= INF_TIME;
        thread_send_min[idx] <= INF_TIME;
        thread_done[idx] <= (idx == tc_i);
        idx <= idx + 1'b1;
        if (idx == tc_i) begin
          for (int i = 0; i < SLOTS; i++)
            if (IW'(i) > tc_i) begin
              thread_min[i] <= INF_TIME; thread_send_min[i] <= INF_TIME;
              thread_done[i] <= 1'b0;
            end
        end
      end
      if (cmd.red_init) begin
        acc <= INF_TIME;
        idx <= '0;
        rem <= {1'b0, node_id} + 7'd1;
        mod_k <= 3'd5;
      end
      if (cmd.red_step) begin
        acc <= (thread_min[idx] < acc) ? thread_min[idx] : acc;
        idx <= idx + 1'b1;
      end
      if (cmd.mod_step) begin
        if ({6'b0, rem} >= mod_sub) rem <= rem - mod_sub[6:0];
        mod_k <= mod_k - 3'd1;
      end
      if (cmd.exec) begin
        case (r_kind)
          K_TICK: begin
            if (stat.tick_start) begin
              if (!global_started && node_id == 6'd0) begin
                red_min <= INF_TIME;
                cur_color <= ~cur_color;
                held_count <= base_val;
                if (base_color) red_count <= '0; else white_count <= '0;
                global_started <= 1'b1;
              end
              waiting_threads <= tc;
              local_started <= 1'b1;
            end
          end
          K_START: if (phase == PH_IDLE && node_id == 6'd0) phase <= PH_LOCAL;
          K_SENT: begin
            if (cur_color) red_count <= red_count + 32'd1;
            else white_count <= white_count + 32'd1;
            if (cur_color != base_color && r_ts < red_min) red_min <= r_ts;
          end
          K_RECV: begin
            if (r_mcol) red_count <= red_count - 32'd1;
            else white_count <= white_count - 32'd1;
          end
          K_TOKEN: begin
            if (node_id == 6'd0) begin
              if (stat.bcast) begin
                phase <= PH_GLOBAL;
                global_started <= 1'b0;
              end else begin
                if (r_tsnd < red_min) red_min <= r_tsnd;
                held_count <= base_val + r_tcnt;
                if (base_color) red_count <= '0; else white_count <= '0;
                phase <= PH_LOCAL;
              end
            end else begin
              if (cur_color == base_color) begin
                red_min <= r_tsnd;
                cur_color <= ~cur_color;
              end else if (r_tsnd < red_min) red_min <= r_tsnd;
              if (r_tclk < ring_min_clock) ring_min_clock <= r_tclk;
              held_count <= base_val + r_tcnt;
              if (base_color) red_count <= '0; else white_count <= '0;
              phase <= PH_LOCAL;
            end
          end
          K_TIME: begin
            time_value <= r_new;
            ring_min_clock <= INF_TIME;
            base_color <= ~base_color;
            if (phase == PH_GLOBAL) phase <= PH_IDLE;
            time_updated <= 1'b1;
          end
          K_TMIN: begin
            if (slot_ok && r_seen && !thread_done[ti_i]) begin
              thread_min[ti_i] <= (r_ts < thread_send_min[ti_i]) ? r_ts
                                  : thread_send_min[ti_i];
              thread_done[ti_i] <= 1'b1;
              if (waiting_threads != 5'd0) waiting_threads <= waiting_threads - 5'd1;
            end
          end
          default: begin
            if (slot_ok && waiting_threads != 5'd0 && !thread_done[ti_i] &&
                r_ts < thread_send_min[ti_i])
              thread_send_min[ti_i] <= r_ts;
          end
        endcase
      end
      if (cmd.bc_init) begin
        bc <= '0;
        bc_time <= (r_tclk < r_tsnd) ? r_tclk : r_tsnd;
      end
      if (cmd.emit_status) begin
        result_kind <= R_STATUS; dest_node <= '0;
        send_color <= (r_kind == K_SENT) ? cur_color : 1'b0;
        out_clock <= '0; out_send <= '0; out_count <= '0;
        current_time <= time_value; time_fresh <= time_updated;
        pending_threads <= waiting_threads; time_updated <= 1'b0;
      end
      if (cmd.emit_bcast) begin
        result_kind <= R_UPDATE; dest_node <= bc[5:0]; send_color <= 1'b0;
        out_clock <= bc_time; out_send <= '0; out_count <= '0;
        current_time <= time_value; time_fresh <= time_updated;
        pending_threads <= waiting_threads;
        if (stat.bc_last) time_updated <= 1'b0;
        bc <= bc + 7'd1;
      end
      if (cmd.fin_tick) begin
        local_started <= 1'b0;
        send_color <= 1'b0;
        current_time <= (pc > 7'd1) ? time_value : acc;
        time_fresh <= (pc > 7'd1) ? time_updated : 1'b1;
        pending_threads <= waiting_threads;
        time_updated <= 1'b0;
        if (pc > 7'd1) begin
          phase <= PH_GLOBAL;
          if (node_id == 6'd0) ring_min_clock <= INF_TIME;
          result_kind <= R_TOKEN; dest_node <= rem[5:0];
          out_clock <= (node_id == 6'd0 || acc < ring_min_clock) ? acc : ring_min_clock;
          out_send <= red_min; out_count <= held_count;
        end else begin
          phase <= PH_IDLE; time_value <= acc;
          result_kind <= R_STATUS; dest_node <= '0;
          out_clock <= '0; out_send <= '0; out_count <= '0;
        end
      end
    end
  end
endmodule

@@ sv/gvt_token_ring_engine.sv @@
// Top level of the global virtual time engine for a Mattern token ring
// Most items give one result: the item is loaded, decoded and applied, then a status result is emitted.
// Tick that opens a round: thread table clear walk, then a status result.
// Tick that reduces: minimum walk, then next node remainder, then a token or status result.
// Broadcast token: one update result per node (process_count clamped to 1..MAX_NODES), one a cycle.
// Synchronous reset restores state and configuration registers; results cannot be stalled.
module gvt_token_ring_engine import gvt_pkg::*; #(
  parameter int MAX_NODES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [2:0]  kind,
  input  logic [31:0] timestamp,
  input  logic        msg_color,
  input  logic [4:0]  thread_index,
  input  logic        round_seen,
  input  logic [31:0] token_clock,
  input  logic [31:0] token_send,
  input  logic signed [31:0] token_count,
  input  logic [31:0] new_time,
  output logic        result_valid,
  output logic [1:0]  result_kind,
  output logic [5:0]  dest_node,
  output logic        send_color,
  output logic [31:0] out_clock,
  output logic [31:0] out_send,
  output logic signed [31:0] out_count,
  output logic [31:0] current_time,
  output logic        time_fresh,
  output logic [4:0]  pending_threads,
  output logic        last
);
`include "gvt_token_ring_engine_defines.svh"
  gvt_cmd_t cmd;
  gvt_stat_t stat;

  assign cfg_ready = 1'b1;

  gvt_ctrl u_ctrl (.clk, .rst, .start, .busy, .stat, .cmd);

  gvt_dp #(.MAX_NODES(MAX_NODES)) u_dp (
    .clk, .rst, .cmd, .stat, .cfg_valid, .cfg_index, .cfg_data,
    .kind, .timestamp, .msg_color, .thread_index, .round_seen,
    .token_clock, .token_send, .token_count, .new_time,
    .result_valid, .result_kind, .dest_node, .send_color, .out_clock,
    .out_send, .out_count, .current_time, .time_fresh, .pending_threads, .last
  );

  `GVT_ASSERT_NEXT(a_start_busy, start && !busy, busy)
  `GVT_ASSERT_IMPL(a_last_valid, last, result_valid)
  `GVT_ASSERT_IMPL(a_last_idle, result_valid && last, !busy)
endmodule

@@ sim/gvt_token_ring_engine_tb.sv @@
// Self-checking testbench for the global virtual time engine with a built-in behavioral predictor
module gvt_token_ring_engine_tb import gvt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] timestamp;
    logic        msg_color;
    logic [4:0]  thread_index;
    logic        round_seen;
    logic [31:0] token_clock;
    logic [31:0] token_send;
    logic [31:0] token_count;
    logic [31:0] new_time;
  } event_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  dest;
    logic        color;
    logic [31:0] clock;
    logic [31:0] send;
    logic [31:0] count;
    logic [31:0] ctime;
    logic        fresh;
    logic [4:0]  pending;
    logic        last;
  } gvt_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = CFG_NODE;
  logic [31:0] cfg_data = '0;
  logic [2:0] kind = K_TICK;
  logic [31:0] timestamp = '0;
  logic msg_color = 1'b0;
  logic [4:0] thread_index = '0;
  logic round_seen = 1'b0;
  logic [31:0] token_clock = '0;
  logic [31:0] token_send = '0;
  logic signed [31:0] token_count = '0;
  logic [31:0] new_time = '0;
  logic result_valid;
  logic [1:0] result_kind;
  logic [5:0] dest_node;
  logic send_color;
  logic [31:0] out_clock;
  logic [31:0] out_send;
  logic signed [31:0] out_count;
  logic [31:0] current_time;
  logic time_fresh;
  logic [4:0] pending_threads;
  logic last;

  gvt_token_ring_engine dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  event_t pending_items[$];
  gvt_result_t expected_results[$];
  event_t in_flight;
  int errors = 0;
  int idle_pct = 35;
  int queued = 0;

  // predictor copy of configuration and state
  logic [5:0] node_reg = '0;
  logic [6:0] proc_reg = 7'd1;
  logic [4:0] thr_reg = 5'd1;
  logic [1:0] ph = PH_IDLE;
  logic cur_col = 1'b0, base_col = 1'b0;
  logic [31:0] white_cnt = 0, red_cnt = 0, held_cnt = 0;
  logic [31:0] red_min = INF_TIME, ring_min = INF_TIME, time_val = 0;
  logic time_upd = 1'b0, local_go = 1'b0, global_go = 1'b0;
  logic [4:0] waiting = '0;
  logic [31:0] thr_min[17];
  logic [31:0] thr_smin[17];
  logic thr_done[17];

  initial begin
    for (int i = 0; i < 17; i++) begin
      thr_min[i] = INF_TIME;
      thr_smin[i] = INF_TIME;
      thr_done[i] = 1'b0;
    end
  end

  function automatic int eff_threads();
    return (thr_reg > 16) ? 16 : thr_reg;
  endfunction

  function automatic int eff_nodes();
    if (proc_reg == 0) return 1;
    return (proc_reg > 64) ? 64 : proc_reg;
  endfunction

  function automatic logic [31:0] umin(logic [31:0] a, logic [31:0] b);
    return (a < b) ? a : b;
  endfunction

  // fold the base-colored counter into the held count, plus an addend
  function automatic void drain_base(logic [31:0] add);
    if (base_col) begin
      held_cnt = red_cnt + add;
      red_cnt = 0;
    end else begin
      held_cnt = white_cnt + add;
      white_cnt = 0;
    end
  endfunction

  function automatic void apply_event(event_t e);
    gvt_result_t out[$];
    gvt_result_t r;
    int tc, pc;
    logic scol;
    logic [31:0] m;
    tc = eff_threads();
    pc = eff_nodes();
    scol = 1'b0;
    r = '0;
    case (e.kind)
      K_TICK: begin
        if (ph == PH_LOCAL) begin
          if (waiting == 0 && !local_go) begin
            if (!global_go && node_reg == 0) begin
              red_min = INF_TIME;
              cur_col = ~cur_col;
              drain_base(0);
              global_go = 1'b1;
            end
            for (int i = 0; i < 17; i++) begin
              thr_min[i] = INF_TIME;
              thr_smin[i] = INF_TIME;
              thr_done[i] = 1'b0;
            end
            thr_done[tc] = 1'b1;
            waiting = 5'(tc);
            local_go = 1'b1;
          end else if (waiting == 0) begin
            m = INF_TIME;
            for (int i = 0; i <= tc; i++) m = umin(m, thr_min[i]);
            if (pc > 1) begin
              ph = PH_GLOBAL;
              if (node_reg == 0) ring_min = INF_TIME;
              r.kind = R_TOKEN;
              r.dest = 6'((node_reg + 1) % pc);
              r.clock = umin(m, ring_min);
              r.send = red_min;
              r.count = held_cnt;
              out.push_back(r);
            end else begin
              ph = PH_IDLE;
              time_val = m;
              time_upd = 1'b1;
            end
            local_go = 1'b0;
          end
        end
      end
      K_START: if (ph == PH_IDLE && node_reg == 0) ph = PH_LOCAL;
      K_SENT: begin
        scol = cur_col;
        if (cur_col) red_cnt++;
        else white_cnt++;
        if (cur_col != base_col) red_min = umin(red_min, e.timestamp);
      end
      K_RECV: begin
        if (e.msg_color) red_cnt--;
        else white_cnt--;
      end
      K_TOKEN: begin
        if (node_reg == 0) begin
          if (e.token_count[31] || e.token_count == 0) begin
            for (int i = 0; i < pc; i++) begin
              r = '0;
              r.kind = R_UPDATE;
              r.dest = 6'(i);
              r.clock = umin(e.token_clock, e.token_send);
              out.push_back(r);
            end
            ph = PH_GLOBAL;
            global_go = 1'b0;
          end else begin
            red_min = umin(e.token_send, red_min);
            drain_base(e.token_count);
            ph = PH_LOCAL;
          end
        end else begin
          if (cur_col == base_col) begin
            red_min = INF_TIME;
            cur_col = ~cur_col;
          end
          red_min = umin(e.token_send, red_min);
          ring_min = umin(ring_min, e.token_clock);
          drain_base(e.token_count);
          ph = PH_LOCAL;
        end
      end
      K_TIME: begin
        time_val = e.new_time;
        ring_min = INF_TIME;
        base_col = ~base_col;
        if (ph == PH_GLOBAL) ph = PH_IDLE;
        time_upd = 1'b1;
      end
      K_TMIN: begin
        if (e.thread_index <= tc && e.round_seen && !thr_done[e.thread_index]) begin
          thr_min[e.thread_index] = umin(thr_smin[e.thread_index], e.timestamp);
          thr_done[e.thread_index] = 1'b1;
          if (waiting > 0) waiting--;
        end
      end
      default: begin
        if (e.thread_index <= tc && waiting > 0 && !thr_done[e.thread_index])
          thr_smin[e.thread_index] = umin(thr_smin[e.thread_index], e.timestamp);
      end
    endcase
    if (out.size() == 0) begin
      r = '0;
      r.kind = R_STATUS;
      r.color = scol;
      out.push_back(r);
    end
    foreach (out[k]) begin
      out[k].ctime = time_val;
      out[k].fresh = time_upd;
      out[k].pending = waiting;
      out[k].last = (k == out.size() - 1);
      expected_results.push_back(out[k]);
    end
    time_upd = 1'b0;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) apply_event(in_flight);
      if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
        in_flight = pending_items.pop_front();
        kind <= in_flight.kind;
        timestamp <= in_flight.timestamp;
        msg_color <= in_flight.msg_color;
        thread_index <= in_flight.thread_index;
        round_seen <= in_flight.round_seen;
        token_clock <= in_flight.token_clock;
        token_send <= in_flight.token_send;
        token_count <= in_flight.token_count;
        new_time <= in_flight.new_time;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    gvt_result_t got, want;
    if (!rst && result_valid) begin
      got = '{result_kind, dest_node, send_color, out_clock, out_send, out_count,
              current_time, time_fresh, pending_threads, last};
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result exp none got %p", $time, got);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          $display("%0t mismatch exp %p got %p", $time, want, got);
          errors++;
        end
      end
    end
  end

  function automatic logic [31:0] rand_ts();
    case ($urandom_range(3))
      0: return $urandom_range(1000);
      1: return INF_TIME;
      default: return $urandom;
    endcase
  endfunction

  function automatic event_t make_event(logic [2:0] k);
    event_t e;
    e.kind = k;
    e.timestamp = rand_ts();
    e.msg_color = 1'($urandom_range(1));
    e.thread_index = 5'($urandom_range(31));
    e.round_seen = 1'($urandom_range(1));
    e.token_clock = rand_ts();
    e.token_send = rand_ts();
    case ($urandom_range(3))
      0: e.token_count = 0;
      1: e.token_count = $urandom_range(20);
      default: e.token_count = $urandom;
    endcase
    e.new_time = rand_ts();
    return e;
  endfunction

  function automatic void queue_event(event_t e);
    pending_items.push_back(e);
    queued++;
  endfunction

  function automatic void queue_noise();
    logic [2:0] k;
    k = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : (($urandom_range(1)) ? K_SENT : K_RECV);
    queue_event(make_event(k));
  endfunction

  function automatic void queue_reports();
    event_t e;
    int tc;
    tc = eff_threads();
    for (int i = 0; i < tc; i++) begin
      if ($urandom_range(2) == 0) begin
        e = make_event(K_SMIN);
        e.thread_index = 5'(i);
        queue_event(e);
      end
      if ($urandom_range(3) == 0) queue_noise();
      e = make_event(K_TMIN);
      e.thread_index = 5'(i);
      e.round_seen = ($urandom_range(7) != 0);
      queue_event(e);
    end
  endfunction

  // one well-formed pass through a round for the configured node
  function automatic void queue_round();
    event_t e;
    if (node_reg == 0) begin
      queue_event(make_event(K_START));
      if ($urandom_range(1)) queue_noise();
      queue_event(make_event(K_TICK));
      queue_reports();
      queue_event(make_event(K_TICK));
      if (eff_nodes() > 1) begin
        e = make_event(K_TOKEN);
        queue_event(e);
        if (e.token_count != 0 && !e.token_count[31]) begin
          queue_event(make_event(K_TICK));
          queue_reports();
          queue_event(make_event(K_TICK));
        end
        queue_event(make_event(K_TIME));
      end
    end else begin
      queue_event(make_event(K_TOKEN));
      queue_noise();
      queue_event(make_event(K_TICK));
      queue_reports();
      queue_event(make_event(K_TICK));
      queue_event(make_event(K_TIME));
    end
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_NODE: node_reg = val[5:0];
      CFG_PROC: proc_reg = val[6:0];
      default: thr_reg = val[4:0];
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_items.size() != 0 || start || expected_results.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  int setups[8][3] = '{'{0, 1, 1}, '{0, 4, 3}, '{5, 8, 16}, '{0, 64, 2},
                       '{63, 127, 31}, '{0, 0, 0}, '{3, 2, 5}, '{0, 3, 4}};

  initial begin
    event_t e;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: reset configuration, single node, every kind and corner
    queue_event(make_event(K_TICK));
    queue_event(make_event(K_START));
    e = make_event(K_SENT); e.timestamp = 0; queue_event(e);
    e = make_event(K_RECV); e.msg_color = 1'b0; queue_event(e);
    e = make_event(K_RECV); e.msg_color = 1'b1; queue_event(e);
    e = make_event(K_TMIN); e.thread_index = 5'd1; e.round_seen = 1'b1; queue_event(e);
    queue_event(make_event(K_TICK));
    e = make_event(K_SENT); e.timestamp = INF_TIME; queue_event(e);
    e = make_event(K_SMIN); e.thread_index = 5'd0; e.timestamp = 7; queue_event(e);
    e = make_event(K_SMIN); e.thread_index = 5'd31; queue_event(e);
    e = make_event(K_TMIN); e.thread_index = 5'd31; e.round_seen = 1'b1; queue_event(e);
    e = make_event(K_TMIN); e.thread_index = 5'd0; e.round_seen = 1'b0; queue_event(e);
    e = make_event(K_TMIN); e.thread_index = 5'd0; e.round_seen = 1'b1; e.timestamp = 9;
    queue_event(e);
    e = make_event(K_TMIN); e.thread_index = 5'd0; e.round_seen = 1'b1; queue_event(e);
    queue_event(make_event(K_TICK));
    queue_event(make_event(K_TICK));
    e = make_event(K_TOKEN); e.token_count = 0; queue_event(e);
    e = make_event(K_TOKEN); e.token_count = 32'h8000_0000; queue_event(e);
    e = make_event(K_TOKEN); e.token_count = 32'h7FFF_FFFF; queue_event(e);
    e = make_event(K_TIME); e.new_time = 0; queue_event(e);
    e = make_event(K_TIME); e.new_time = INF_TIME; queue_event(e);
    queue_event(make_event(K_START));
    drain();

    foreach (setups[p]) begin
      write_reg(CFG_NODE, setups[p][0] | ($urandom << 6));
      write_reg(CFG_PROC, setups[p][1] | ($urandom << 7));
      write_reg(CFG_THREAD, setups[p][2] | ($urandom << 5));
      idle_pct = (p == 2) ? 0 : 35;
      queued = 0;
      while (queued < 40) begin
        if ($urandom_range(4) == 0) queue_noise();
        else queue_round();
      end
      drain();
    end

    if (errors == 0) $display("[gvt_token_ring_engine] OK");
    else $display("[gvt_token_ring_engine] ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("[gvt_token_ring_engine] ERROR");
    $finish;
  end
endmodule
